[hw/rtl/tle_pkg.sv]
// ----------------------------------------------------------------------------
// tle_pkg
// Shared widths, byte codes, result kinds and sequencer-to-output structs
// for the terminal line editor.
// ----------------------------------------------------------------------------
package tle_pkg;

   localparam int LINE_CAP_DEF = 16;
   localparam int BYTE_W       = 8;
   localparam int KIND_W       = 2;
   localparam int POS_W        = 5;
   localparam int MAX_RESULTS  = 48;
   localparam int CNT_W        = $clog2(MAX_RESULTS + 1);

   // result kinds
   localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CHAR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

   // terminal byte codes
   localparam logic [BYTE_W-1:0] CH_NUL      = 8'h00;
   localparam logic [BYTE_W-1:0] CH_ETX      = 8'h03;
   localparam logic [BYTE_W-1:0] CH_BEL      = 8'h07;
   localparam logic [BYTE_W-1:0] CH_BS       = 8'h08;
   localparam logic [BYTE_W-1:0] CH_LF       = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR       = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_ESC      = 8'h1B;
   localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
   localparam logic [BYTE_W-1:0] CH_DIGIT1   = 8'h31;
   localparam logic [BYTE_W-1:0] CH_DIGIT3   = 8'h33;
   localparam logic [BYTE_W-1:0] CH_KEY_UP   = 8'h41;
   localparam logic [BYTE_W-1:0] CH_KEY_DOWN = 8'h42;
   localparam logic [BYTE_W-1:0] CH_KEY_RT   = 8'h43;
   localparam logic [BYTE_W-1:0] CH_KEY_LT   = 8'h44;
   localparam logic [BYTE_W-1:0] CH_KEY_END  = 8'h46;
   localparam logic [BYTE_W-1:0] CH_LETTER_C = 8'h43;
   localparam logic [BYTE_W-1:0] CH_SS3      = 8'h4F;
   localparam logic [BYTE_W-1:0] CH_CSI      = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_CARET    = 8'h5E;
   localparam logic [BYTE_W-1:0] CH_TILDE    = 8'h7E;
   localparam logic [BYTE_W-1:0] CH_PRINT_LO = 8'h20;
   localparam logic [BYTE_W-1:0] CH_PRINT_HI = 8'h7E;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data;
      logic [POS_W-1:0]  length;
   } result_type;

   typedef struct packed {
      logic       gen_valid;
      logic       done;
      result_type res;
   } seq_ctl_type;

endpackage

[hw/rtl/tle_if.sv]
// ----------------------------------------------------------------------------
// tle_if
// Valid/ready channels of the line editor: received bytes in, results out.
// ----------------------------------------------------------------------------
interface tle_req_if;
   import tle_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tle_rsp_if;
   import tle_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] out_kind;
   logic [BYTE_W-1:0] out_byte;
   logic [POS_W-1:0]  line_length;
   logic              last;

   modport source (output valid, output out_kind, output out_byte, output line_length,
                   output last, input ready);
   modport sink   (input valid, input out_kind, input out_byte, input line_length,
                   input last, output ready);
endinterface

[hw/rtl/tle_ram.sv]
// ----------------------------------------------------------------------------
// tle_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module tle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/tle_ctrl.sv]
// ----------------------------------------------------------------------------
// tle_ctrl
// Byte decoder and edit sequencer: decodes each received byte, then walks
// the line RAM to shift, redraw and flush, issuing one result word at a time.
// ----------------------------------------------------------------------------
module tle_ctrl #(
   parameter int LINE_CAP = tle_pkg::LINE_CAP_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   tle_req_if.sink                     req,
   output logic                        mem_we,
   output logic [$clog2(LINE_CAP)-1:0] mem_waddr,
   output logic [tle_pkg::BYTE_W-1:0]  mem_wdata,
   output logic [$clog2(LINE_CAP)-1:0] mem_raddr,
   input  logic [tle_pkg::BYTE_W-1:0]  mem_rdata,
   output tle_pkg::seq_ctl_type        ctl,
   input  logic                        stage_free
);
   import tle_pkg::*;

   localparam int               ADDR_W  = $clog2(LINE_CAP);
   localparam logic [POS_W-1:0] CAP_POS = POS_W'(LINE_CAP);

   typedef enum logic [3:0] {
      S_IDLE, S_NEXT, S_REP, S_SHR_RD, S_SHR_WR, S_SHL_RD, S_SHL_WR,
      S_STR_RD, S_STR_EM, S_MARK, S_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_INS, OP_BS, OP_DEL, OP_BEEP, OP_CTC, OP_FIN,
      OP_LEFT, OP_RIGHT, OP_HOME, OP_END
   } op_type;

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [3:0]        step_ff, step_in;
   logic [POS_W-1:0]  cursor_ff, cursor_in;
   logic [POS_W-1:0]  end_ff, end_in;
   logic              esc_active_ff, esc_active_in;
   logic [1:0]        esc_count_ff, esc_count_in;
   logic [BYTE_W-1:0] esc0_ff, esc0_in;
   logic [BYTE_W-1:0] esc1_ff, esc1_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic [POS_W-1:0]  idx_ff, idx_in;
   logic [POS_W-1:0]  stop_ff, stop_in;
   logic [POS_W-1:0]  rep_ff, rep_in;
   logic [BYTE_W-1:0] rep_byte_ff, rep_byte_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic              emit;
   result_type        emit_res;
   logic              fire;
   logic              at_max;
   logic              seq_done;
   logic [POS_W-1:0]  idx_dec;
   logic [POS_W-1:0]  idx_inc;
   logic [BYTE_W-1:0] b;

   assign b       = req.rx_byte;
   assign idx_dec = idx_ff - 1'b1;
   assign idx_inc = idx_ff + 1'b1;
   assign at_max  = (cnt_ff == CNT_W'(MAX_RESULTS));
   assign req.ready = (state_ff == S_IDLE);

   always_comb begin
      case (state_ff)
         S_SHR_RD, S_SHR_WR: mem_raddr = idx_dec[ADDR_W-1:0];
         S_SHL_RD, S_SHL_WR: mem_raddr = idx_inc[ADDR_W-1:0];
         default:            mem_raddr = idx_ff[ADDR_W-1:0];
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      step_in       = step_ff;
      cursor_in     = cursor_ff;
      end_in        = end_ff;
      esc_active_in = esc_active_ff;
      esc_count_in  = esc_count_ff;
      esc0_in       = esc0_ff;
      esc1_in       = esc1_ff;
      byte_in       = byte_ff;
      idx_in        = idx_ff;
      stop_in       = stop_ff;
      rep_in        = rep_ff;
      rep_byte_in   = rep_byte_ff;
      kind_in       = kind_ff;
      cnt_in        = cnt_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff[ADDR_W-1:0];
      mem_wdata     = mem_rdata;
      emit          = 1'b0;
      emit_res      = '0;
      seq_done      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               byte_in  = b;
               step_in  = '0;
               op_in    = OP_NONE;
               state_in = S_NEXT;
               if (esc_active_ff) begin
                  if (b == CH_ETX) begin
                     esc_active_in = 1'b0;
                     esc_count_in  = '0;
                  end else if (esc_count_ff == 2'd0) begin
                     esc0_in      = b;
                     esc_count_in = 2'd1;
                  end else if (esc_count_ff == 2'd1) begin
                     if (esc0_ff == CH_CSI && (b == CH_KEY_UP || b == CH_KEY_DOWN)) begin
                        esc_active_in = 1'b0;
                        esc_count_in  = '0;
                     end else if (esc0_ff == CH_CSI && b == CH_KEY_RT) begin
                        esc_active_in = 1'b0;
                        esc_count_in  = '0;
                        op_in = (cursor_ff < end_ff) ? OP_RIGHT : OP_BEEP;
                     end else if (esc0_ff == CH_CSI && b == CH_KEY_LT) begin
                        esc_active_in = 1'b0;
                        esc_count_in  = '0;
                        op_in = (cursor_ff != '0) ? OP_LEFT : OP_BEEP;
                     end else if (esc0_ff == CH_SS3 && b == CH_KEY_END) begin
                        esc_active_in = 1'b0;
                        esc_count_in  = '0;
                        op_in = OP_END;
                     end else begin
                        esc1_in      = b;
                        esc_count_in = 2'd2;
                     end
                  end else begin
                     // third byte: match or drop the whole sequence
                     esc_active_in = 1'b0;
                     esc_count_in  = '0;
                     if (esc0_ff == CH_CSI && esc1_ff == CH_DIGIT1 && b == CH_TILDE) begin
                        op_in = OP_HOME;
                     end else if (esc0_ff == CH_CSI && esc1_ff == CH_DIGIT3 &&
                                  b == CH_TILDE) begin
                        if (end_ff != '0 && cursor_ff != end_ff) begin
                           op_in   = OP_DEL;
                           step_in = 4'd3;
                        end else begin
                           op_in = OP_BEEP;
                        end
                     end
                  end
               end else if (b inside {[CH_PRINT_LO:CH_PRINT_HI]}) begin
                  if (end_ff < CAP_POS) begin
                     op_in = OP_INS;
                  end
               end else if (b == CH_BS) begin
                  op_in = (end_ff != '0 && cursor_ff != '0) ? OP_BS : OP_BEEP;
               end else if (b == CH_ETX) begin
                  op_in = OP_CTC;
               end else if (b == CH_ESC) begin
                  esc_active_in = 1'b1;
                  esc_count_in  = '0;
               end else if (b == CH_CR || b == CH_LF) begin
                  op_in = OP_FIN;
               end
            end
         end

         S_NEXT: begin
            step_in = step_ff + 1'b1;
            case (op_ff)
               OP_INS: begin
                  case (step_ff)
                     4'd0: begin
                        rep_byte_in = byte_ff;
                        rep_in      = POS_W'(1);
                        state_in    = S_REP;
                     end
                     4'd1: begin
                        idx_in   = end_ff;
                        state_in = S_SHR_RD;
                     end
                     4'd2: begin
                        mem_we    = 1'b1;
                        mem_waddr = cursor_ff[ADDR_W-1:0];
                        mem_wdata = byte_ff;
                        cursor_in = cursor_ff + 1'b1;
                        end_in    = end_ff + 1'b1;
                     end
                     4'd3: begin
                        kind_in  = KIND_ECHO;
                        idx_in   = cursor_ff;
                        stop_in  = end_ff;
                        state_in = S_STR_RD;
                     end
                     4'd4: begin
                        rep_byte_in = CH_BS;
                        rep_in      = end_ff - cursor_ff;
                        state_in    = S_REP;
                     end
                     4'd5: begin
                        // full line: flush it as on CR
                        if (end_ff == CAP_POS) begin
                           kind_in  = KIND_CHAR;
                           idx_in   = '0;
                           stop_in  = end_ff;
                           state_in = S_STR_RD;
                        end else begin
                           state_in = S_DONE;
                        end
                     end
                     4'd6:    state_in = S_MARK;
                     default: state_in = S_DONE;
                  endcase
               end

               OP_BS, OP_DEL: begin
                  case (step_ff)
                     4'd0, 4'd2: begin
                        rep_byte_in = CH_BS;
                        rep_in      = POS_W'(1);
                        state_in    = S_REP;
                     end
                     4'd1: begin
                        rep_byte_in = CH_SPACE;
                        rep_in      = POS_W'(1);
                        state_in    = S_REP;
                     end
                     4'd3: begin
                        if (op_ff == OP_BS) begin
                           cursor_in = cursor_ff - 1'b1;
                           idx_in    = cursor_ff - 1'b1;
                        end else begin
                           idx_in = cursor_ff;
                        end
                        state_in = S_SHL_RD;
                     end
                     4'd4: end_in = end_ff - 1'b1;
                     4'd5: begin
                        kind_in  = KIND_ECHO;
                        idx_in   = cursor_ff;
                        stop_in  = end_ff;
                        state_in = S_STR_RD;
                     end
                     4'd6: begin
                        rep_byte_in = CH_SPACE;
                        rep_in      = POS_W'(1);
                        state_in    = S_REP;
                     end
                     4'd7: begin
                        rep_byte_in = CH_BS;
                        rep_in      = end_ff - cursor_ff + 1'b1;
                        state_in    = S_REP;
                     end
                     default: state_in = S_DONE;
                  endcase
               end

               OP_BEEP: begin
                  if (step_ff == 4'd0) begin
                     rep_byte_in = CH_BEL;
                     rep_in      = POS_W'(3);
                     state_in    = S_REP;
                  end else begin
                     state_in = S_DONE;
                  end
               end

               OP_CTC: begin
                  case (step_ff)
                     4'd0: begin
                        rep_byte_in = CH_CARET;
                        rep_in      = POS_W'(1);
                        state_in    = S_REP;
                     end
                     4'd1: begin
                        rep_byte_in = CH_LETTER_C;
                        rep_in      = POS_W'(1);
                        state_in    = S_REP;
                     end
                     4'd2: begin
                        // abandon the line: marker carries length zero
                        cursor_in = '0;
                        end_in    = '0;
                        state_in  = S_MARK;
                     end
                     default: state_in = S_DONE;
                  endcase
               end

               OP_FIN: begin
                  case (step_ff)
                     4'd0: begin
                        kind_in  = KIND_CHAR;
                        idx_in   = '0;
                        stop_in  = end_ff;
                        state_in = S_STR_RD;
                     end
                     4'd1:    state_in = S_MARK;
                     default: state_in = S_DONE;
                  endcase
               end

               OP_LEFT: begin
                  if (step_ff == 4'd0) begin
                     rep_byte_in = CH_BS;
                     rep_in      = POS_W'(1);
                     cursor_in   = cursor_ff - 1'b1;
                     state_in    = S_REP;
                  end else begin
                     state_in = S_DONE;
                  end
               end

               OP_RIGHT: begin
                  if (step_ff == 4'd0) begin
                     kind_in  = KIND_ECHO;
                     idx_in   = cursor_ff;
                     stop_in  = cursor_ff + 1'b1;
                     state_in = S_STR_RD;
                  end else begin
                     cursor_in = cursor_ff + 1'b1;
                     state_in  = S_DONE;
                  end
               end

               OP_HOME: begin
                  if (step_ff == 4'd0) begin
                     rep_byte_in = CH_BS;
                     rep_in      = cursor_ff;
                     cursor_in   = '0;
                     state_in    = S_REP;
                  end else begin
                     state_in = S_DONE;
                  end
               end

               OP_END: begin
                  if (step_ff == 4'd0) begin
                     kind_in  = KIND_ECHO;
                     idx_in   = cursor_ff;
                     stop_in  = end_ff;
                     state_in = S_STR_RD;
                  end else begin
                     cursor_in = end_ff;
                     state_in  = S_DONE;
                  end
               end

               default: state_in = S_DONE;
            endcase
         end

         S_REP: begin
            if (rep_ff == '0) begin
               state_in = S_NEXT;
            end else begin
               emit          = 1'b1;
               emit_res.kind = KIND_ECHO;
               emit_res.data = rep_byte_ff;
               if (fire) begin
                  rep_in = rep_ff - 1'b1;
               end
            end
         end

         // insert: move entries up by one, top down, toward the cursor
         S_SHR_RD: begin
            state_in = (idx_ff > cursor_ff) ? S_SHR_WR : S_NEXT;
         end
         S_SHR_WR: begin
            mem_we   = 1'b1;
            idx_in   = idx_dec;
            state_in = S_SHR_RD;
         end

         // remove: move entries down by one, from the hole upward
         S_SHL_RD: begin
            state_in = (idx_inc < end_ff) ? S_SHL_WR : S_NEXT;
         end
         S_SHL_WR: begin
            mem_we   = 1'b1;
            idx_in   = idx_inc;
            state_in = S_SHL_RD;
         end

         S_STR_RD: begin
            state_in = (idx_ff < stop_ff) ? S_STR_EM : S_NEXT;
         end
         S_STR_EM: begin
            emit          = 1'b1;
            emit_res.kind = kind_ff;
            emit_res.data = mem_rdata;
            if (fire) begin
               idx_in   = idx_inc;
               state_in = S_STR_RD;
            end
         end

         S_MARK: begin
            emit            = 1'b1;
            emit_res.kind   = KIND_END;
            emit_res.data   = CH_NUL;
            emit_res.length = end_ff;
            if (fire) begin
               cursor_in = '0;
               end_in    = '0;
               state_in  = S_DONE;
            end
         end

         S_DONE: begin
            seq_done = 1'b1;
            if (stage_free) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // past the result bound the sequence still runs, without output
      if (emit && !at_max && stage_free) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   assign fire          = emit && (at_max || stage_free);
   assign ctl.gen_valid = emit && !at_max;
   assign ctl.done      = seq_done;
   assign ctl.res       = emit_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         op_ff         <= OP_NONE;
         step_ff       <= '0;
         cursor_ff     <= '0;
         end_ff        <= '0;
         esc_active_ff <= 1'b0;
         esc_count_ff  <= '0;
         esc0_ff       <= '0;
         esc1_ff       <= '0;
         cnt_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         step_ff       <= step_in;
         cursor_ff     <= cursor_in;
         end_ff        <= end_in;
         esc_active_ff <= esc_active_in;
         esc_count_ff  <= esc_count_in;
         esc0_ff       <= esc0_in;
         esc1_ff       <= esc1_in;
         cnt_ff        <= cnt_in;
      end
      byte_ff     <= byte_in;
      idx_ff      <= idx_in;
      stop_ff     <= stop_in;
      rep_ff      <= rep_in;
      rep_byte_ff <= rep_byte_in;
      kind_ff     <= kind_in;
   end

   a_cursor_in_line: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= end_ff)
      else $error("cursor beyond line end");

   a_line_bounded: assert property (@(posedge clock) disable iff (reset)
      end_ff <= CAP_POS)
      else $error("line longer than capacity");

   a_count_cleared: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |-> (cnt_ff == '0))
      else $error("result count not cleared at byte accept");

endmodule

[hw/rtl/tle_out.sv]
// ----------------------------------------------------------------------------
// tle_out
// Result staging: holds the newest word one step back so the last flag can
// be set when the sequence ends, and drives the registered result channel.
// ----------------------------------------------------------------------------
module tle_out (
   input  logic                 clock,
   input  logic                 reset,
   input  tle_pkg::seq_ctl_type ctl,
   output logic                 stage_free,
   tle_rsp_if.source            rsp
);
   import tle_pkg::*;

   logic       hold_valid_ff, hold_valid_in;
   result_type hold_ff, hold_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_res_ff, rsp_res_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       push;

   assign stage_free = !hold_valid_ff || !rsp_valid_ff || rsp.ready;
   assign push       = hold_valid_ff && stage_free && (ctl.gen_valid || ctl.done);

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      rsp_res_in    = rsp_res_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;

      if (ctl.gen_valid && stage_free) begin
         hold_valid_in = 1'b1;
         hold_in       = ctl.res;
      end else if (ctl.done && stage_free) begin
         hold_valid_in = 1'b0;
      end

      // advance the held word; it is the final one when the sequence ends
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = hold_ff;
         rsp_last_in  = ctl.done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      hold_ff     <= hold_in;
      rsp_res_ff  <= rsp_res_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_kind    = rsp_res_ff.kind;
   assign rsp.out_byte    = rsp_res_ff.data;
   assign rsp.line_length = rsp_res_ff.length;
   assign rsp.last        = rsp_last_ff;

   a_done_drains: assert property (@(posedge clock) disable iff (reset)
      (ctl.done && stage_free) |=> !hold_valid_ff)
      else $error("held word left after sequence end");

   a_gen_or_done: assert property (@(posedge clock) disable iff (reset)
      !(ctl.gen_valid && ctl.done))
      else $error("new word and sequence end together");

endmodule

[hw/rtl/terminal_line_editor_unit.sv]
// ----------------------------------------------------------------------------
// terminal_line_editor_unit
// Terminal line editor: takes received bytes one word at a time on req_chan
// and returns echo bytes, finished line characters and end markers on
// rsp_chan, with last set on the final word caused by each byte. The line is
// held in a LINE_CAP-entry RAM with one write and one registered read port;
// every character that is shifted or read back is first read, then written
// or sent, and each repeated echo byte is sent as a word of its own; the
// least work per byte is for ignored bytes and escape prefixes, the most for
// an insert at the start of an almost full line that then flushes, and the
// work waits while rsp_chan stalls. A new byte is taken once the previous
// one's words have all been handed to the output register. The RAM needs no
// clearing after reset.
// ----------------------------------------------------------------------------
module terminal_line_editor_unit #(
   parameter int LINE_CAP = tle_pkg::LINE_CAP_DEF
) (
   input  logic      clock,
   input  logic      reset,
   tle_req_if.sink   req_chan,
   tle_rsp_if.source rsp_chan
);
   import tle_pkg::*;

   localparam int ADDR_W = $clog2(LINE_CAP);

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [BYTE_W-1:0] mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;
   logic [BYTE_W-1:0] mem_rdata;
   seq_ctl_type       ctl;
   logic              stage_free;

   tle_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (LINE_CAP)
   ) u_line_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   tle_ctrl #(
      .LINE_CAP (LINE_CAP)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata),
      .ctl        (ctl),
      .stage_free (stage_free)
   );

   tle_out u_out (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .stage_free (stage_free),
      .rsp        (rsp_chan)
   );

endmodule

[sim/tb_terminal_line_editor_unit.sv]
// ----------------------------------------------------------------------------
// tb_terminal_line_editor_unit
// Self-checking bench for the terminal line editor. A queue of received bytes
// (directed key sequences, then random typing, cursor keys, edits, line ends,
// broken escapes and filler bytes) feeds a valid/ready driver with random
// gaps. A monitor predicts every echo, line character and end marker per
// accepted byte and checks each result word in order under random back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_terminal_line_editor_unit;
   import tle_pkg::*;

   localparam int LINE_CAP    = LINE_CAP_DEF;
   localparam int RANDOM_KEYS = 480;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_WAIT  = 200;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data;
      logic [POS_W-1:0]  length;
      logic              last;
   } editor_word_type;

   typedef enum int {
      ACT_TEXT, ACT_LEFT, ACT_RIGHT, ACT_HOME, ACT_END, ACT_DELETE, ACT_UP_DOWN,
      ACT_BACKSPACE, ACT_ENTER, ACT_CTRL_C, ACT_BAD_ESC, ACT_NOISE
   } key_action_type;

   logic clock = 1'b0;
   logic reset;

   tle_req_if req_if ();
   tle_rsp_if rsp_if ();

   terminal_line_editor_unit #(.LINE_CAP(LINE_CAP)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #10 clock = ~clock;

   // stimulus and bookkeeping
   logic [BYTE_W-1:0] rx_queue [$];
   int bytes_total;
   int bytes_taken = 0;
   int noise_bytes = 0;
   int words_seen  = 0;
   int lines_done  = 0;
   int mismatches  = 0;
   int idle_cycles = 0;

   // line editor shadow state
   logic [BYTE_W-1:0] line_mem [LINE_CAP];
   int unsigned       cur_pos  = 0;
   int unsigned       fill     = 0;
   bit                esc_on   = 1'b0;
   int                esc_n    = 0;
   logic [BYTE_W-1:0] esc_first = '0;
   logic [BYTE_W-1:0] esc_mid   = '0;
   int                step_words;
   editor_word_type   awaited_words [$];
   editor_word_type   head_word;

   // handshake tracking for the driver and sink
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   int   req_gap = 0, req_quiet = 0, req_draw;
   int   rsp_stall = 0, rsp_quiet = 0, rsp_draw;

   // ------------------------------------------------------------------
   // shadow model of the editor
   // ------------------------------------------------------------------
   function automatic void emit_word(input logic [KIND_W-1:0] kind,
                                     input logic [BYTE_W-1:0] data,
                                     input logic [POS_W-1:0] length);
      editor_word_type w;
      if (step_words >= MAX_RESULTS) return;
      w.kind   = kind;
      w.data   = data;
      w.length = length;
      w.last   = 1'b0;
      awaited_words.push_back(w);
      step_words++;
   endfunction

   function automatic void emit_run(input logic [BYTE_W-1:0] data, input int unsigned n);
      for (int unsigned i = 0; i < n; i++) emit_word(KIND_ECHO, data, '0);
   endfunction

   function automatic void ring_bell();
      emit_run(CH_BEL, 3);
   endfunction

   function automatic void echo_tail();
      for (int unsigned i = cur_pos; i < fill && i < LINE_CAP; i++)
         emit_word(KIND_ECHO, line_mem[i], '0);
   endfunction

   function automatic void remove_char(input int unsigned p);
      for (int unsigned i = p; i + 1 < fill && i + 1 < LINE_CAP; i++)
         line_mem[i] = line_mem[i + 1];
      fill--;
   endfunction

   function automatic void redraw_after_remove();
      int unsigned tail;
      tail = fill - cur_pos;
      echo_tail();
      emit_word(KIND_ECHO, CH_SPACE, '0);
      emit_run(CH_BS, tail + 1);
   endfunction

   function automatic void flush_line();
      for (int unsigned i = 0; i < fill && i < LINE_CAP; i++)
         emit_word(KIND_CHAR, line_mem[i], '0);
      emit_word(KIND_END, CH_NUL, POS_W'(fill));
      cur_pos = 0;
      fill    = 0;
   endfunction

   function automatic void predict_byte(input logic [BYTE_W-1:0] b);
      int unsigned tail;
      step_words = 0;
      if (esc_on) begin
         if (b == CH_ETX) begin
            esc_on = 1'b0;
            esc_n  = 0;
         end else if (esc_n == 0) begin
            esc_first = b;
            esc_n     = 1;
         end else if (esc_n == 1) begin
            if (esc_first == CH_CSI && (b == CH_KEY_UP || b == CH_KEY_DOWN)) begin
               esc_on = 1'b0;
               esc_n  = 0;
            end else if (esc_first == CH_CSI && b == CH_KEY_RT) begin
               esc_on = 1'b0;
               esc_n  = 0;
               if (cur_pos < fill) begin
                  emit_word(KIND_ECHO, line_mem[cur_pos], '0);
                  cur_pos++;
               end else ring_bell();
            end else if (esc_first == CH_CSI && b == CH_KEY_LT) begin
               esc_on = 1'b0;
               esc_n  = 0;
               if (cur_pos > 0) begin
                  emit_word(KIND_ECHO, CH_BS, '0);
                  cur_pos--;
               end else ring_bell();
            end else if (esc_first == CH_SS3 && b == CH_KEY_END) begin
               esc_on = 1'b0;
               esc_n  = 0;
               echo_tail();
               cur_pos = fill;
            end else begin
               esc_mid = b;
               esc_n   = 2;
            end
         end else begin
            esc_on = 1'b0;
            esc_n  = 0;
            if (esc_first == CH_CSI && esc_mid == CH_DIGIT1 && b == CH_TILDE) begin
               emit_run(CH_BS, cur_pos);
               cur_pos = 0;
            end else if (esc_first == CH_CSI && esc_mid == CH_DIGIT3 && b == CH_TILDE) begin
               if (fill != 0 && cur_pos != fill) begin
                  remove_char(cur_pos);
                  redraw_after_remove();
               end else ring_bell();
            end
         end
      end else if (b >= CH_PRINT_LO && b <= CH_PRINT_HI) begin
         if (fill < LINE_CAP && cur_pos <= fill) begin
            emit_word(KIND_ECHO, b, '0);
            for (int unsigned i = fill; i > cur_pos; i--) line_mem[i] = line_mem[i - 1];
            line_mem[cur_pos] = b;
            cur_pos++;
            fill++;
            tail = fill - cur_pos;
            echo_tail();
            emit_run(CH_BS, tail);
            if (fill >= LINE_CAP) flush_line();
         end
      end else if (b == CH_BS) begin
         if (fill != 0 && cur_pos != 0) begin
            emit_word(KIND_ECHO, CH_BS, '0);
            emit_word(KIND_ECHO, CH_SPACE, '0);
            emit_word(KIND_ECHO, CH_BS, '0);
            cur_pos--;
            remove_char(cur_pos);
            redraw_after_remove();
         end else ring_bell();
      end else if (b == CH_ETX) begin
         emit_word(KIND_ECHO, CH_CARET, '0);
         emit_word(KIND_ECHO, CH_LETTER_C, '0);
         fill    = 0;
         cur_pos = 0;
         flush_line();
      end else if (b == CH_ESC) begin
         esc_on = 1'b1;
         esc_n  = 0;
      end else if (b == CH_CR || b == CH_LF) begin
         flush_line();
      end
      if (step_words > 0) awaited_words[awaited_words.size() - 1].last = 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // stimulus building
   // ------------------------------------------------------------------
   task automatic queue_byte(input logic [BYTE_W-1:0] b);
      rx_queue.push_back(b);
   endtask

   task automatic queue_key(input key_action_type act);
      int n;
      case (act)
         ACT_TEXT: begin
            n = $urandom_range(1, 5);
            repeat (n) queue_byte(BYTE_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)));
         end
         ACT_LEFT: begin
            queue_byte(CH_ESC); queue_byte(CH_CSI); queue_byte(CH_KEY_LT);
         end
         ACT_RIGHT: begin
            queue_byte(CH_ESC); queue_byte(CH_CSI); queue_byte(CH_KEY_RT);
         end
         ACT_HOME: begin
            queue_byte(CH_ESC); queue_byte(CH_CSI); queue_byte(CH_DIGIT1); queue_byte(CH_TILDE);
         end
         ACT_END: begin
            queue_byte(CH_ESC); queue_byte(CH_SS3); queue_byte(CH_KEY_END);
         end
         ACT_DELETE: begin
            queue_byte(CH_ESC); queue_byte(CH_CSI); queue_byte(CH_DIGIT3); queue_byte(CH_TILDE);
         end
         ACT_UP_DOWN: begin
            queue_byte(CH_ESC); queue_byte(CH_CSI);
            queue_byte($urandom_range(0, 1) ? CH_KEY_UP : CH_KEY_DOWN);
         end
         ACT_BACKSPACE: queue_byte(CH_BS);
         ACT_ENTER:     queue_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
         ACT_CTRL_C:    queue_byte(CH_ETX);
         ACT_BAD_ESC: begin
            queue_byte(CH_ESC);
            case ($urandom_range(0, 3))
               0: repeat (3) queue_byte(BYTE_W'($urandom_range(0, 255)));
               1: begin
                  queue_byte(CH_CSI);
                  repeat (2) queue_byte(BYTE_W'($urandom_range(0, 255)));
               end
               2: begin
                  queue_byte(CH_CSI);
                  queue_byte(CH_ETX);
               end
               default: begin
                  queue_byte(CH_CSI);
                  queue_byte($urandom_range(0, 1) ? CH_DIGIT1 : CH_DIGIT3);
                  queue_byte(BYTE_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)));
               end
            endcase
         end
         default: begin
            // filler: high bytes, DEL, random control codes (BS, ETX, ESC, CR, LF among them are acted on)
            case ($urandom_range(0, 2))
               0:       queue_byte(BYTE_W'($urandom_range(128, 255)));
               1:       queue_byte(8'h7F);
               default: queue_byte(BYTE_W'($urandom_range(0, 31)));
            endcase
            noise_bytes++;
         end
      endcase
   endtask

   task automatic report_fault(input string what);
      if (mismatches < 10) $display("%s", what);
      mismatches++;
   endtask

   // ------------------------------------------------------------------
   // driver: present one byte at a time, random gap after each
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap      <= 0;
      end else if (req_if.valid && !req_taken) begin
         // hold the word until it is taken
      end else if (req_gap != 0) begin
         req_if.valid <= 1'b0;
         req_gap      <= req_gap - 1;
      end else if (rx_queue.size() != 0) begin
         if (req_quiet != 0) begin
            req_draw = 0;
            req_quiet <= req_quiet - 1;
         end else begin
            req_draw = $urandom_range(0, 12);
            if ($urandom_range(0, 15) == 0) req_quiet <= $urandom_range(8, 40);
         end
         req_if.valid   <= 1'b1;
         req_if.rx_byte <= rx_queue.pop_front();
         req_gap        <= req_draw;
      end else begin
         req_if.valid <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // sink: random stall after each result word
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall    <= 0;
      end else if (rsp_taken) begin
         if (rsp_quiet != 0) begin
            rsp_draw = 0;
            rsp_quiet <= rsp_quiet - 1;
         end else begin
            rsp_draw = $urandom_range(0, 12);
            if ($urandom_range(0, 15) == 0) rsp_quiet <= $urandom_range(8, 60);
         end
         if (rsp_draw == 0) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b0;
            rsp_stall    <= rsp_draw - 1;
         end
      end else if (rsp_stall != 0) begin
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // monitor: check results first, then predict the byte taken this edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         rsp_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         rsp_taken <= rsp_if.valid && rsp_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            words_seen++;
            if (awaited_words.size() == 0) begin
               report_fault($sformatf("unexpected word %0d: kind %0d byte %02h len %0d last %0d",
                  words_seen, rsp_if.out_kind, rsp_if.out_byte, rsp_if.line_length,
                  rsp_if.last));
            end else begin
               head_word = awaited_words.pop_front();
               if (head_word.kind != rsp_if.out_kind || head_word.data != rsp_if.out_byte ||
                   head_word.length != rsp_if.line_length || head_word.last != rsp_if.last)
                  report_fault($sformatf({"mismatch on word %0d: expected kind %0d byte %02h ",
                     "len %0d last %0d, got kind %0d byte %02h len %0d last %0d"},
                     words_seen, head_word.kind, head_word.data, head_word.length,
                     head_word.last, rsp_if.out_kind, rsp_if.out_byte, rsp_if.line_length,
                     rsp_if.last));
               if (head_word.kind == KIND_END) lines_done++;
            end
         end
         if (req_if.valid && req_if.ready) begin
            predict_byte(req_if.rx_byte);
            bytes_taken++;
         end
      end
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d of %0d bytes taken",
                     idle_cycles, bytes_taken, bytes_total);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------
   initial begin
      int pick;
      int leftover;
      key_action_type act;

      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.rx_byte = '0;
      rsp_if.ready   = 1'b0;

      // directed: field extremes, cursor and edit keys, refused edits, escape corner cases
      queue_byte(CH_PRINT_LO);
      queue_byte(CH_PRINT_HI);
      queue_key(ACT_LEFT);
      queue_key(ACT_HOME);
      queue_byte(CH_BS);              // refused at line start
      queue_key(ACT_DELETE);
      queue_key(ACT_RIGHT);
      queue_key(ACT_END);
      queue_byte(CH_ESC);             // Ctrl-C inside an escape
      queue_byte(CH_ETX);
      queue_byte(8'hFF);
      queue_byte(CH_ESC);             // three bytes, no match
      queue_byte(CH_CSI);
      queue_byte(CH_DIGIT1);
      queue_byte(CH_SPACE);
      queue_byte(CH_CR);
      queue_byte(CH_ETX);

      // random: mostly typing and editing, some broken escapes and filler
      while (rx_queue.size() - noise_bytes < RANDOM_KEYS + 26) begin
         pick = $urandom_range(0, 99);
         if      (pick < 42) act = ACT_TEXT;
         else if (pick < 50) act = ACT_LEFT;
         else if (pick < 56) act = ACT_RIGHT;
         else if (pick < 60) act = ACT_HOME;
         else if (pick < 64) act = ACT_END;
         else if (pick < 70) act = ACT_DELETE;
         else if (pick < 72) act = ACT_UP_DOWN;
         else if (pick < 80) act = ACT_BACKSPACE;
         else if (pick < 86) act = ACT_ENTER;
         else if (pick < 89) act = ACT_CTRL_C;
         else if (pick < 94) act = ACT_BAD_ESC;
         else                act = ACT_NOISE;
         queue_key(act);
      end
      bytes_total = rx_queue.size();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (bytes_taken == bytes_total);
      while (awaited_words.size() != 0) @(posedge clock);
      // let any stray trailing word show up
      repeat (DRAIN_WAIT) @(posedge clock);
      leftover = awaited_words.size();
      if (leftover != 0) $display("%0d expected words never arrived", leftover);

      $display("Run covered %0d received bytes (%0d filler), %0d result words, %0d lines",
               bytes_total, noise_bytes, words_seen, lines_done);
      $display("Mismatched or unexpected words: %0d, missing words: %0d",
               mismatches, leftover);
      if (mismatches == 0 && leftover == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
